>>> src/view_facing_normal_clamp_unit_macros.svh
// Assertion macros shared by the view-facing normal clamp RTL.
`ifndef VIEW_FACING_NORMAL_CLAMP_UNIT_MACROS_SVH
`define VIEW_FACING_NORMAL_CLAMP_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on clk, off during reset.
`define VFNC_ASSERT_IMPL(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("view_facing_normal_clamp: check failed");
// Next-cycle implication, checked on clk, off during reset.
`define VFNC_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("view_facing_normal_clamp: check failed");
`else
`define VFNC_ASSERT_IMPL(name, pre, post)
`define VFNC_ASSERT_NEXT(name, pre, post)
`endif
`endif

>>> src/vfnc_pkg.sv
// Shared widths, stage map and types of the view-facing normal clamp.
`timescale 1ns / 1ps
package vfnc_pkg;

  localparam int FRAC_BITS = 14;
  localparam int CMP_W     = 16;
  localparam int MARGIN_W  = 15;
  localparam logic [MARGIN_W-1:0] MARGIN_RST = 15'd164;

  // Cosine path widths
  localparam int DOT_W  = 33;
  localparam int NN_W   = 32;
  localparam int PROD_W = 64;
  localparam int RT1_W  = 32;
  localparam int QW     = FRAC_BITS + 1;
  localparam int NUM1_W = 33 + FRAC_BITS;
  localparam int HI_W   = (FRAC_BITS > 15) ? FRAC_BITS : 15;
  localparam int E_W    = HI_W + 3;
  localparam int D_W    = HI_W + 2;
  localparam int SUMM_W = HI_W + 18;
  localparam int M_W    = HI_W + 19 - FRAC_BITS;

  // Renormalize path widths
  localparam int LEN2_W = 2 * M_W;
  localparam int RT2_W  = M_W;
  localparam int NUM2_W = M_W + FRAC_BITS;

  // Stage map of the cosine pipe
  localparam int CP_SQ0  = 2;
  localparam int CP_PREP = CP_SQ0 + RT1_W;
  localparam int CP_DIV0 = CP_PREP + 1;
  localparam int CP_E    = CP_DIV0 + QW;
  localparam int CP_F    = CP_E + 1;
  localparam int CP_NST  = CP_F + 1;

  // Stage map of the renormalize pipe
  localparam int NP_SQ0  = 1;
  localparam int NP_PREP = NP_SQ0 + RT2_W;
  localparam int NP_DIV0 = NP_PREP + 1;
  localparam int NP_NST  = NP_DIV0 + QW;

  typedef logic signed [CMP_W-1:0] cmp_t;

  typedef struct packed {
    logic [2:0][CMP_W-1:0] n;
    logic [2:0][CMP_W-1:0] r;
    logic [DOT_W-1:0]      dot;
    logic                  tiny;
    logic                  last;
  } cp_side_t;

  // Moved normal handed from the cosine pipe to the renormalize pipe
  typedef struct packed {
    logic [2:0][M_W-1:0] m;
    logic                pushed;
    logic                last;
  } mv_t;

  // Quotients and flags handed from the renormalize pipe to the output stage
  typedef struct packed {
    logic [2:0][QW-1:0] q;
    logic [2:0]         neg;
    logic               zero;
    logic               pushed;
    logic               last;
  } np_res_t;

endpackage

>>> src/vfnc_cos_pipe.sv
// Cosine pipe: dot and norms, pipelined isqrt and divide, push along the ray.
`timescale 1ns / 1ps
module vfnc_cos_pipe import vfnc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0][CMP_W-1:0] in_n,
  input  logic [2:0][CMP_W-1:0] in_r,
  input  logic                in_last,
  input  logic [MARGIN_W-1:0] margin,
  output logic                out_valid,
  input  logic                out_ready,
  output mv_t                 out_mv
);

  localparam logic [PROD_W-1:0] SS = PROD_W'(1) << (2 * FRAC_BITS);
  localparam logic signed [E_W-1:0] S_E = E_W'(1) <<< FRAC_BITS;

  logic [CP_NST-1:0] v_r;
  logic [CP_NST:0]   rdy;
  cp_side_t          side_r [0:CP_E];
  cp_side_t          side_in;

  logic signed [DOT_W-1:0] dot_c;
  logic [NN_W-1:0]         nn_c, rr_c, nn_r, rr_r;
  logic [PROD_W-1:0]       prod_r;
  logic [DOT_W-1:0]        dot_mag;

  logic [PROD_W-1:0] sq_rem_r  [0:RT1_W-1];
  logic [RT1_W-1:0]  sq_root_r [0:RT1_W-1];

  logic [NUM1_W-1:0] dv_rem_r [0:QW];
  logic [QW-1:0]     dv_q_r   [0:QW];
  logic [RT1_W-1:0]  dv_den_r [0:QW];
  logic              dv_neg_r [0:QW];

  logic                    pushed_c, pushed_r;
  logic signed [D_W-1:0]   d_c, d_r;
  mv_t                     mv_c, mv_r;

  // Stall chain: a stage moves when empty or when the next one moves
  assign rdy[CP_NST] = out_ready;
  for (genvar k = 0; k < CP_NST; k++) begin : g_rdy
    assign rdy[k] = !v_r[k] || rdy[k+1];
  end
  assign in_ready  = rdy[0];
  assign out_valid = v_r[CP_NST-1];

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < CP_NST; k++) begin
        if (rdy[k]) begin
          v_r[k] <= (k == 0) ? in_valid : v_r[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  // Dot product and squared norms of the request
  always_comb begin
    logic signed [NN_W-1:0] nsq, rsq;
    dot_c = '0;
    nn_c  = '0;
    rr_c  = '0;
    for (int i = 0; i < 3; i++) begin
      nsq   = $signed(in_n[i]) * $signed(in_n[i]);
      rsq   = $signed(in_r[i]) * $signed(in_r[i]);
      dot_c = dot_c + DOT_W'($signed(in_n[i]) * $signed(in_r[i]));
      nn_c  = nn_c + $unsigned(nsq);
      rr_c  = rr_c + $unsigned(rsq);
    end
  end

  assign side_in = '{n: in_n, r: in_r, dot: dot_c, tiny: 1'b0, last: in_last};

  // Carry the request alongside each stage
  for (genvar k = 0; k <= CP_E; k++) begin : g_side
    if (k == 0) begin : g_load
      always_ff @(posedge clk) begin
        if (rdy[0]) begin
          side_r[0] <= side_in;
        end
      end
    end else if (k == CP_SQ0) begin : g_tiny
      always_ff @(posedge clk) begin
        if (rdy[k]) begin
          side_r[k] <= '{n: side_r[k-1].n, r: side_r[k-1].r, dot: side_r[k-1].dot,
                         tiny: (prod_r < SS), last: side_r[k-1].last};
        end
      end
    end else begin : g_copy
      always_ff @(posedge clk) begin
        if (rdy[k]) begin
          side_r[k] <= side_r[k-1];
        end
      end
    end
  end

  // Hold norms, then their product
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      nn_r <= nn_c;
      rr_r <= rr_c;
    end
    if (rdy[1]) begin
      prod_r <= nn_r * rr_r;
    end
  end

  // Square root of the norm product, one root bit per stage
  for (genvar j = 0; j < RT1_W; j++) begin : g_sq
    localparam int B = RT1_W - 1 - j;
    logic [PROD_W-1:0] rem_s;
    logic [RT1_W-1:0]  root_s;
    logic [PROD_W:0]   trial;
    logic              ge;
    if (j == 0) begin : g_src0
      assign rem_s  = prod_r;
      assign root_s = '0;
    end else begin : g_srcn
      assign rem_s  = sq_rem_r[j-1];
      assign root_s = sq_root_r[j-1];
    end
    assign trial = ((PROD_W+1)'(root_s) << (B + 1)) | ((PROD_W+1)'(1) << (2 * B));
    assign ge    = {1'b0, rem_s} >= trial;
    always_ff @(posedge clk) begin
      if (rdy[CP_SQ0+j]) begin
        sq_rem_r[j]  <= ge ? rem_s - trial[PROD_W-1:0] : rem_s;
        sq_root_r[j] <= ge ? (root_s | (RT1_W'(1) << B)) : root_s;
      end
    end
  end

  // Magnitude of the dot product, taken at its own width
  assign dot_mag = side_r[CP_PREP-1].dot[DOT_W-1] ? -side_r[CP_PREP-1].dot
                                                   : side_r[CP_PREP-1].dot;

  // Set up the rounded divide |dot| * S / root
  always_ff @(posedge clk) begin
    if (rdy[CP_PREP]) begin
      dv_neg_r[0] <= side_r[CP_PREP-1].dot[DOT_W-1];
      dv_rem_r[0] <= (NUM1_W'(dot_mag) << FRAC_BITS)
                     + NUM1_W'(sq_root_r[RT1_W-1] >> 1);
      dv_den_r[0] <= sq_root_r[RT1_W-1];
      dv_q_r[0]   <= '0;
    end
  end

  // Restoring divide, one quotient bit per stage
  for (genvar j = 0; j < QW; j++) begin : g_dv
    localparam int B = QW - 1 - j;
    logic [NUM1_W-1:0] trial;
    logic              ge;
    assign trial = NUM1_W'(dv_den_r[j]) << B;
    assign ge    = dv_rem_r[j] >= trial;
    always_ff @(posedge clk) begin
      if (rdy[CP_DIV0+j]) begin
        dv_rem_r[j+1] <= ge ? dv_rem_r[j] - trial : dv_rem_r[j];
        dv_q_r[j+1]   <= dv_q_r[j] | (ge ? (QW'(1) << B) : '0);
        dv_den_r[j+1] <= dv_den_r[j];
        dv_neg_r[j+1] <= dv_neg_r[j];
      end
    end
  end

  // Signed cosine, clamp, compare with the margin
  always_comb begin
    logic signed [E_W-1:0] q_e, c_e, m_e, diff_e;
    q_e = E_W'({1'b0, dv_q_r[QW]});
    c_e = dv_neg_r[QW] ? -q_e : q_e;
    if (c_e > S_E) begin
      c_e = S_E;
    end
    if (c_e < -S_E) begin
      c_e = -S_E;
    end
    if (side_r[CP_E-1].tiny) begin
      c_e = '0;
    end
    m_e      = E_W'({1'b0, margin});
    diff_e   = m_e - c_e;
    pushed_c = c_e < m_e;
    d_c      = pushed_c ? D_W'(diff_e) : '0;
  end

  always_ff @(posedge clk) begin
    if (rdy[CP_E]) begin
      pushed_r <= pushed_c;
      d_r      <= d_c;
    end
  end

  // Move the normal along the ray and round back to FRAC_BITS
  always_comb begin
    logic signed [CMP_W+D_W-1:0] p;
    logic signed [SUMM_W-1:0]    v;
    logic [SUMM_W-1:0]           mag, rq;
    logic [M_W-1:0]              mval;
    mv_c = '0;
    for (int i = 0; i < 3; i++) begin
      p    = $signed(side_r[CP_E].r[i]) * d_r;
      v    = (SUMM_W'($signed(side_r[CP_E].n[i])) <<< FRAC_BITS) + SUMM_W'(p);
      mag  = v[SUMM_W-1] ? $unsigned(-v) : $unsigned(v);
      rq   = (mag + (SUMM_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      mval = M_W'(rq);
      mv_c.m[i] = v[SUMM_W-1] ? -mval : mval;
    end
    mv_c.pushed = pushed_r;
    mv_c.last   = side_r[CP_E].last;
  end

  always_ff @(posedge clk) begin
    if (rdy[CP_F]) begin
      mv_r <= mv_c;
    end
  end

  assign out_mv = mv_r;

endmodule

>>> src/vfnc_norm_pipe.sv
// Renormalize pipe: length squared, pipelined isqrt, three-lane divide.
`timescale 1ns / 1ps
module vfnc_norm_pipe import vfnc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  mv_t     in_mv,
  output logic    out_valid,
  input  logic    out_ready,
  output np_res_t out_res
);

  logic [NP_NST-1:0] v_r;
  logic [NP_NST:0]   rdy;
  mv_t               sd_r [0:NP_NST-1];

  logic [LEN2_W-1:0] len2_c, len2_r;
  logic [LEN2_W-1:0] sq_rem_r  [0:RT2_W-1];
  logic [RT2_W-1:0]  sq_root_r [0:RT2_W-1];

  logic [2:0][NUM2_W-1:0] dv_rem_r  [0:QW];
  logic [2:0][QW-1:0]     dv_q_r    [0:QW];
  logic [RT2_W-1:0]       dv_den_r  [0:QW];
  logic [2:0]             dv_neg_r  [0:QW];
  logic                   dv_zero_r [0:QW];
  logic [2:0][NUM2_W-1:0] num_c;
  logic [2:0]             neg_c;

  // Stall chain
  assign rdy[NP_NST] = out_ready;
  for (genvar k = 0; k < NP_NST; k++) begin : g_rdy
    assign rdy[k] = !v_r[k] || rdy[k+1];
  end
  assign in_ready  = rdy[0];
  assign out_valid = v_r[NP_NST-1];

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NP_NST; k++) begin
        if (rdy[k]) begin
          v_r[k] <= (k == 0) ? in_valid : v_r[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  // Carry the moved normal and flags
  for (genvar k = 0; k < NP_NST; k++) begin : g_side
    if (k == 0) begin : g_load
      always_ff @(posedge clk) begin
        if (rdy[0]) begin
          sd_r[0] <= in_mv;
        end
      end
    end else begin : g_copy
      always_ff @(posedge clk) begin
        if (rdy[k]) begin
          sd_r[k] <= sd_r[k-1];
        end
      end
    end
  end

  // Squared length of the moved normal
  always_comb begin
    logic signed [LEN2_W-1:0] msq;
    len2_c = '0;
    for (int i = 0; i < 3; i++) begin
      msq    = $signed(in_mv.m[i]) * $signed(in_mv.m[i]);
      len2_c = len2_c + $unsigned(msq);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      len2_r <= len2_c;
    end
  end

  // Square root of the length, one root bit per stage
  for (genvar j = 0; j < RT2_W; j++) begin : g_sq
    localparam int B = RT2_W - 1 - j;
    logic [LEN2_W-1:0] rem_s;
    logic [RT2_W-1:0]  root_s;
    logic [LEN2_W:0]   trial;
    logic              ge;
    if (j == 0) begin : g_src0
      assign rem_s  = len2_r;
      assign root_s = '0;
    end else begin : g_srcn
      assign rem_s  = sq_rem_r[j-1];
      assign root_s = sq_root_r[j-1];
    end
    assign trial = ((LEN2_W+1)'(root_s) << (B + 1)) | ((LEN2_W+1)'(1) << (2 * B));
    assign ge    = {1'b0, rem_s} >= trial;
    always_ff @(posedge clk) begin
      if (rdy[NP_SQ0+j]) begin
        sq_rem_r[j]  <= ge ? rem_s - trial[LEN2_W-1:0] : rem_s;
        sq_root_r[j] <= ge ? (root_s | (RT2_W'(1) << B)) : root_s;
      end
    end
  end

  // Set up |m| * S / len for each lane
  always_comb begin
    logic [M_W-1:0] mag;
    for (int i = 0; i < 3; i++) begin
      neg_c[i] = sd_r[NP_PREP-1].m[i][M_W-1];
      mag      = neg_c[i] ? -sd_r[NP_PREP-1].m[i] : sd_r[NP_PREP-1].m[i];
      num_c[i] = (NUM2_W'(mag) << FRAC_BITS) + NUM2_W'(sq_root_r[RT2_W-1] >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NP_PREP]) begin
      dv_rem_r[0]  <= num_c;
      dv_q_r[0]    <= '0;
      dv_den_r[0]  <= sq_root_r[RT2_W-1];
      dv_neg_r[0]  <= neg_c;
      dv_zero_r[0] <= (sq_root_r[RT2_W-1] == '0);
    end
  end

  // Restoring divide in three lanes sharing one divisor
  for (genvar j = 0; j < QW; j++) begin : g_dv
    localparam int B = QW - 1 - j;
    logic [NUM2_W-1:0]      trial;
    logic [2:0][NUM2_W-1:0] rem_n;
    logic [2:0][QW-1:0]     q_n;
    assign trial = NUM2_W'(dv_den_r[j]) << B;
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        if (dv_rem_r[j][i] >= trial) begin
          rem_n[i] = dv_rem_r[j][i] - trial;
          q_n[i]   = dv_q_r[j][i] | (QW'(1) << B);
        end else begin
          rem_n[i] = dv_rem_r[j][i];
          q_n[i]   = dv_q_r[j][i];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rdy[NP_DIV0+j]) begin
        dv_rem_r[j+1]  <= rem_n;
        dv_q_r[j+1]    <= q_n;
        dv_den_r[j+1]  <= dv_den_r[j];
        dv_neg_r[j+1]  <= dv_neg_r[j];
        dv_zero_r[j+1] <= dv_zero_r[j];
      end
    end
  end

  assign out_res = '{q: dv_q_r[QW], neg: dv_neg_r[QW], zero: dv_zero_r[QW],
                     pushed: sd_r[NP_NST-1].pushed, last: sd_r[NP_NST-1].last};

endmodule

>>> src/view_facing_normal_clamp_unit.sv
// Top level of the view-facing normal clamp: margin register, pipes, output stage.
`timescale 1ns / 1ps
`include "view_facing_normal_clamp_unit_macros.svh"
// Usage:
//   Input channel in_*: one pixel per request, a normal and a viewing ray in
//   signed Q2.14 plus an end-of-map mark. A request is taken on a rising edge
//   with in_valid high and in_stall low.
//   Output channel out_*: the adjusted unit normal, the push flag and the mark,
//   taken on a rising edge with out_valid high and out_stall low.
//   Config channel cfg_*: writes view_margin when cfg_valid is high; cfg_ready
//   is always high. Write only while no request is in flight.
// Pipeline:
//   90 register stages from input to output: 52 stages of cosine pipe (32-step
//   root, 15-step divide), 37 stages of renormalize pipe (20-step root, 15-step
//   divide) and the output register.
//   One request per cycle sustained while out_stall is low.
// Reset and stall:
//   rst_n clears all valid bits and loads view_margin with 164. A stall on the
//   output fills empty stages first and backs up to in_stall; nothing is lost
//   or repeated.
module view_facing_normal_clamp_unit import vfnc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [15:0]  in_normal_x,
  input  logic signed [15:0]  in_normal_y,
  input  logic signed [15:0]  in_normal_z,
  input  logic signed [15:0]  in_ray_x,
  input  logic signed [15:0]  in_ray_y,
  input  logic signed [15:0]  in_ray_z,
  input  logic                in_last_in,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [15:0]  out_fixed_x,
  output logic signed [15:0]  out_fixed_y,
  output logic signed [15:0]  out_fixed_z,
  output logic                out_was_pushed,
  output logic                out_last_out,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [MARGIN_W-1:0] cfg_view_margin
);

  localparam int SAT_W = ((QW + 1) > 17) ? (QW + 1) : 17;
  localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(32767);
  localparam logic signed [SAT_W-1:0] SAT_LO = -SAT_W'(32768);

  logic [MARGIN_W-1:0] margin_r;
  logic                cp_ready, cp_valid, nm_valid, nm_ready, ld;
  logic                nm_in_ready;
  mv_t                 cp_mv;
  np_res_t             nm_res;
  logic                out_valid_r;
  logic [2:0][15:0]    fixed_c, fixed_r;
  logic                pushed_r, last_r;

  // Margin register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_r <= MARGIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      margin_r <= cfg_view_margin;
    end
  end

  assign in_stall = !cp_ready;

  vfnc_cos_pipe u_cos (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (cp_ready),
    .in_n      ({in_normal_z, in_normal_y, in_normal_x}),
    .in_r      ({in_ray_z, in_ray_y, in_ray_x}),
    .in_last   (in_last_in),
    .margin    (margin_r),
    .out_valid (cp_valid),
    .out_ready (nm_in_ready),
    .out_mv    (cp_mv)
  );

  vfnc_norm_pipe u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cp_valid),
    .in_ready  (nm_in_ready),
    .in_mv     (cp_mv),
    .out_valid (nm_valid),
    .out_ready (nm_ready),
    .out_res   (nm_res)
  );

  // Sign, saturate and zero-length override
  always_comb begin
    logic signed [SAT_W-1:0] qs, v;
    for (int i = 0; i < 3; i++) begin
      qs = SAT_W'({1'b0, nm_res.q[i]});
      v  = nm_res.neg[i] ? -qs : qs;
      if (v > SAT_HI) begin
        v = SAT_HI;
      end
      if (v < SAT_LO) begin
        v = SAT_LO;
      end
      fixed_c[i] = nm_res.zero ? 16'd0 : v[15:0];
    end
  end

  // Output register
  assign nm_ready = !out_valid_r || !out_stall;
  assign ld       = nm_valid && nm_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (nm_ready) begin
      out_valid_r <= nm_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      fixed_r  <= fixed_c;
      pushed_r <= nm_res.pushed;
      last_r   <= nm_res.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_fixed_x    = $signed(fixed_r[0]);
  assign out_fixed_y    = $signed(fixed_r[1]);
  assign out_fixed_z    = $signed(fixed_r[2]);
  assign out_was_pushed = pushed_r;
  assign out_last_out   = last_r;

  `VFNC_ASSERT_NEXT(a_load_shows_valid, ld, out_valid_r)
  `VFNC_ASSERT_NEXT(a_zero_len_gives_zero, ld && nm_res.zero, fixed_r == '0)
  `VFNC_ASSERT_NEXT(a_cfg_write_lands, cfg_valid, margin_r == $past(cfg_view_margin))

endmodule
